/* design/window_overlap_keep_filter_defines.svh */
// Assertion macros shared by the checkers of window_overlap_keep_filter.
// No dependencies; take in by `include before use.
`ifndef WINDOW_OVERLAP_KEEP_FILTER_DEFINES_SVH
`define WINDOW_OVERLAP_KEEP_FILTER_DEFINES_SVH

// Implication checked while reset is low.
`define WOL_ASSERT_HOLD(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window_overlap_keep_filter: check failed");

// Next-cycle implication checked at every edge, reset included.
`define WOL_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("window_overlap_keep_filter: check failed");

`endif

/* design/wol_pkg.sv */
// Package for window_overlap_keep_filter: widths, beat types, register codes
// and the span helper. No dependencies.
package wol_pkg;

   localparam int CB        = 12;
   localparam int AREA_BITS = 2 * CB;
   localparam int UNI_BITS  = AREA_BITS + 1;
   localparam int REM_BITS  = UNI_BITS + 1;
   localparam int Q_BITS    = 16;
   localparam int THR_BITS  = 16;

   localparam logic [THR_BITS-1:0] OVERLAP_THR_RESET = 16'd19661;
   localparam logic [THR_BITS-1:0] CONF_THR_RESET    = 16'd16384;

   localparam logic CSR_OVERLAP_THR = 1'b0;
   localparam logic CSR_CONF_THR    = 1'b1;

   typedef struct packed {
      logic [CB-1:0]       win_x;
      logic [CB-1:0]       win_y;
      logic [CB-1:0]       win_w;
      logic [CB-1:0]       win_h;
      logic [Q_BITS-1:0]   confidence;
      logic                tracked_valid;
      logic [CB-1:0]       trk_x;
      logic [CB-1:0]       trk_y;
      logic [CB-1:0]       trk_w;
      logic [CB-1:0]       trk_h;
   } req_type;

   typedef struct packed {
      logic [Q_BITS-1:0] iou;
      logic              overlaps;
      logic              keep;
   } rsp_type;

   typedef struct packed {
      logic [CB-1:0] span_x;
      logic [CB-1:0] span_y;
      logic [CB-1:0] win_w;
      logic [CB-1:0] win_h;
      logic [CB-1:0] trk_w;
      logic [CB-1:0] trk_h;
      logic          tracked;
      logic          conf_keep;
   } span_type;

   typedef struct packed {
      logic [AREA_BITS-1:0] inter;
      logic [AREA_BITS-1:0] area_win;
      logic [AREA_BITS-1:0] area_trk;
      logic                 tracked;
      logic                 conf_keep;
   } area_type;

   typedef struct packed {
      logic [REM_BITS-1:0] rem;
      logic [UNI_BITS-1:0] den;
      logic [Q_BITS-1:0]   quo;
      logic                zero;
      logic                conf_keep;
   } wol_cell_type;

   function automatic logic [CB-1:0] span_len(input logic [CB-1:0] a0,
                                              input logic [CB-1:0] alen,
                                              input logic [CB-1:0] b0,
                                              input logic [CB-1:0] blen);
      logic [CB:0] a1;
      logic [CB:0] b1;
      logic [CB:0] lo;
      logic [CB:0] hi;
      logic [CB:0] diff;
      a1   = {1'b0, a0} + {1'b0, alen};
      b1   = {1'b0, b0} + {1'b0, blen};
      lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
      hi   = (a1 < b1) ? a1 : b1;
      diff = hi - lo;
      return (hi > lo) ? diff[CB-1:0] : '0;
   endfunction

endpackage

/* design/wol_front.sv */
// Front stages of window_overlap_keep_filter: spans, areas, union.
// Depends on wol_pkg; feeds the first divider cell.
module wol_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  wol_pkg::req_type               in_data,
   output logic                           in_ready,
   input  logic [wol_pkg::THR_BITS-1:0]   conf_thr,
   output logic                           out_valid,
   output wol_pkg::wol_cell_type          out_data,
   input  logic                           out_ready
);
   import wol_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   logic         s2_valid_ff, s2_valid_in;
   logic         s3_valid_ff, s3_valid_in;
   span_type     s1_ff, s1_in;
   area_type     s2_ff, s2_in;
   wol_cell_type s3_ff, s3_in;
   logic         rdy1, rdy2, rdy3;
   logic [UNI_BITS-1:0] uni;

   always_comb begin
      rdy3 = !s3_valid_ff || out_ready;
      rdy2 = !s2_valid_ff || rdy3;
      rdy1 = !s1_valid_ff || rdy2;
      in_ready = rdy1;
      s1_valid_in = rdy1 ? in_valid    : s1_valid_ff;
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;
   end

   always_comb begin
      s1_in.span_x    = span_len(in_data.win_x, in_data.win_w, in_data.trk_x, in_data.trk_w);
      s1_in.span_y    = span_len(in_data.win_y, in_data.win_h, in_data.trk_y, in_data.trk_h);
      s1_in.win_w     = in_data.win_w;
      s1_in.win_h     = in_data.win_h;
      s1_in.trk_w     = in_data.trk_w;
      s1_in.trk_h     = in_data.trk_h;
      s1_in.tracked   = in_data.tracked_valid;
      s1_in.conf_keep = in_data.confidence > conf_thr;
   end

   always_comb begin
      s2_in.inter     = AREA_BITS'(s1_ff.span_x) * AREA_BITS'(s1_ff.span_y);
      s2_in.area_win  = AREA_BITS'(s1_ff.win_w) * AREA_BITS'(s1_ff.win_h);
      s2_in.area_trk  = AREA_BITS'(s1_ff.trk_w) * AREA_BITS'(s1_ff.trk_h);
      s2_in.tracked   = s1_ff.tracked;
      s2_in.conf_keep = s1_ff.conf_keep;
   end

   always_comb begin
      uni = {1'b0, s2_ff.area_win} + {1'b0, s2_ff.area_trk} - {1'b0, s2_ff.inter};
      s3_in.rem       = {2'b00, s2_ff.inter};
      s3_in.den       = uni;
      s3_in.quo       = '0;
      s3_in.zero      = !s2_ff.tracked || (uni == '0);
      s3_in.conf_keep = s2_ff.conf_keep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         s1_ff <= s1_in;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

/* design/wol_div_cell.sv */
// One cell of the divider chain: a compare-subtract giving one quotient bit.
// Depends on wol_pkg.
module wol_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  wol_pkg::wol_cell_type in_data,
   output logic                  in_ready,
   output logic                  out_valid,
   output wol_pkg::wol_cell_type out_data,
   input  logic                  out_ready
);
   import wol_pkg::*;

   logic                valid_ff, valid_in;
   wol_cell_type        data_ff, data_in;
   logic [REM_BITS-1:0] den_ext;
   logic [REM_BITS-1:0] diff;
   logic                ge;

   always_comb begin
      den_ext  = {1'b0, in_data.den};
      ge       = in_data.rem >= den_ext;
      diff     = ge ? (in_data.rem - den_ext) : in_data.rem;
      data_in  = in_data;
      data_in.rem = {diff[REM_BITS-2:0], 1'b0};
      data_in.quo = {in_data.quo[Q_BITS-2:0], ge};
      in_ready = !valid_ff || out_ready;
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* design/window_overlap_keep_filter.sv */
// Window overlap keep filter: IoU of a candidate window against a tracked box,
// with overlap and keep decisions. Depends on wol_pkg, wol_front, wol_div_cell.
//
// Usage:
//   req_valid/req_stall/req_data carries one window, its confidence and an
//   optional tracked box per beat; rsp_valid/rsp_stall/rsp_data returns one
//   result beat (iou in Q1.15, overlaps, keep) per request, in order.
//   csr_valid/csr_ready/csr_index/csr_data writes a threshold: index 0 is the
//   overlap threshold, index 1 the confidence threshold. csr_ready is always
//   high; write only while no request is in flight.
//   A request beat passes through three front stages (spans, products,
//   union), sixteen divider cells giving one quotient bit each, and the
//   output register. Throughput is one beat per cycle while rsp_stall is
//   low; every stage holds its own valid bit, so a stalled receiver only
//   stops stages that are full and req_stall rises once the whole chain
//   is full.
//   Reset empties the chain and loads the thresholds with 19661 and 16384;
//   req_stall is low from the first cycle after reset.
module window_overlap_keep_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  wol_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output wol_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [wol_pkg::THR_BITS-1:0]  csr_data
);
   import wol_pkg::*;

   localparam int NCELLS = Q_BITS;

   logic [THR_BITS-1:0] overlap_thr_ff, overlap_thr_in;
   logic [THR_BITS-1:0] conf_thr_ff, conf_thr_in;

   logic                cv [NCELLS+1];
   logic                cr [NCELLS+1];
   wol_cell_type        cd [NCELLS+1];
   logic                front_ready;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                out_ready;
   logic                over;
   wol_cell_type        last;

   assign csr_ready = 1'b1;

   always_comb begin
      overlap_thr_in = overlap_thr_ff;
      conf_thr_in    = conf_thr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OVERLAP_THR: overlap_thr_in = csr_data;
            CSR_CONF_THR:    conf_thr_in    = csr_data;
            default:         overlap_thr_in = overlap_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_thr_ff <= OVERLAP_THR_RESET;
         conf_thr_ff    <= CONF_THR_RESET;
      end else begin
         overlap_thr_ff <= overlap_thr_in;
         conf_thr_ff    <= conf_thr_in;
      end
   end

   wol_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (front_ready),
      .conf_thr  (conf_thr_ff),
      .out_valid (cv[0]),
      .out_data  (cd[0]),
      .out_ready (cr[0])
   );

   assign req_stall = !front_ready;

   for (genvar i = 0; i < NCELLS; i++) begin : g_cell
      wol_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[i]),
         .in_data   (cd[i]),
         .in_ready  (cr[i]),
         .out_valid (cv[i+1]),
         .out_data  (cd[i+1]),
         .out_ready (cr[i+1])
      );
   end

   assign cr[NCELLS] = out_ready;

   always_comb begin
      last      = cd[NCELLS];
      out_ready = !rsp_valid_ff || !rsp_stall;
      over = !last.zero &&
             ((last.quo > overlap_thr_ff) ||
              ((last.quo == overlap_thr_ff) && (last.rem != '0)));
      rsp_data_in.iou      = last.zero ? '0 : last.quo;
      rsp_data_in.overlaps = over;
      rsp_data_in.keep     = last.conf_keep || over;
      rsp_valid_in = out_ready ? cv[NCELLS] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && cv[NCELLS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/wol_checker.sv */
// Port checker for window_overlap_keep_filter, bound to the top level.
// Depends on wol_pkg and window_overlap_keep_filter_defines.svh.
`include "window_overlap_keep_filter_defines.svh"

module wol_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input wol_pkg::rsp_type              rsp_data
);
   import wol_pkg::*;

   `WOL_ASSERT_NEXT(a_reset_empties, clock, reset, !rsp_valid)
   `WOL_ASSERT_NEXT(a_rsp_held, clock, !reset && rsp_valid && rsp_stall, rsp_valid || reset)
   `WOL_ASSERT_HOLD(a_overlap_keeps, clock, reset, rsp_valid && rsp_data.overlaps, rsp_data.keep)
   `WOL_ASSERT_NEXT(a_rsp_stable, clock, !reset && rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind window_overlap_keep_filter wol_checker u_wol_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
